@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TPM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tpm assertion failed");
`define TPM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tpm assertion failed");
`else
`define TPM_ASSERT(label, clk, rst, prop)
`define TPM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ sv/tpm_pkg.sv @@
package tpm_pkg;

   localparam int NumCoeffs  = 4;
   localparam int NumPoints  = 7;
   localparam int NumStages  = 7;

   localparam int AWidth     = 24;
   localparam int BWidth     = 8;
   localparam int XWidth     = 28;
   localparam int YWidth     = 13;
   localparam int ModWidth   = 27;

   localparam int StageEval  = 0;
   localparam int StageMul   = 1;
   localparam int StageLinA  = 2;
   localparam int StageLinB  = 3;
   localparam int StageLinC  = 4;
   localparam int StageInv   = 5;
   localparam int StageOut   = 6;

   localparam logic [ModWidth-1:0] Inv3  = 27'h2AAAAAB;
   localparam logic [ModWidth-1:0] Inv9  = 27'h0E38E39;
   localparam logic [ModWidth-1:0] Inv15 = 27'h6EEEEEF;

   typedef logic [31:0]                       word_type;
   typedef word_type [NumCoeffs-1:0]          coeff_word_type;
   typedef word_type [NumPoints-1:0]          eval_type;
   typedef logic [NumCoeffs-1:0][AWidth-1:0]  a_poly_type;
   typedef logic [NumCoeffs-1:0][BWidth-1:0]  b_poly_type;
   typedef logic [NumPoints-1:0][XWidth-1:0]  x_vec_type;
   typedef logic [NumPoints-1:0][YWidth-1:0]  y_vec_type;
   typedef logic [NumPoints-1:0][ModWidth-1:0] w_vec_type;
   typedef logic [NumCoeffs-1:0][AWidth-1:0]  prod_type;

   typedef struct packed {
      logic [NumStages-1:0] load;
   } pipe_ctl_type;

   // Values at inf, 2, 1, -1, 1/2 (times 8), -1/2 (times 8) and 0, mod 2^32.
   function automatic eval_type evaluate(input coeff_word_type c);
      eval_type e;
      e[0] = c[3];
      e[1] = c[0] + (c[1] << 1) + (c[2] << 2) + (c[3] << 3);
      e[2] = c[0] + c[1] + c[2] + c[3];
      e[3] = c[0] - c[1] + c[2] - c[3];
      e[4] = (c[0] << 3) + (c[1] << 2) + (c[2] << 1) + c[3];
      e[5] = (c[0] << 3) - (c[1] << 2) + (c[2] << 1) - c[3];
      e[6] = c[0];
      return e;
   endfunction

endpackage

@@ sv/tpm_if.sv @@
interface tpm_req_if;
   logic                        valid;
   logic                        ready;
   logic [tpm_pkg::AWidth-1:0]  a_coeff_0;
   logic [tpm_pkg::AWidth-1:0]  a_coeff_1;
   logic [tpm_pkg::AWidth-1:0]  a_coeff_2;
   logic [tpm_pkg::AWidth-1:0]  a_coeff_3;
   logic [tpm_pkg::BWidth-1:0]  b_coeff_0;
   logic [tpm_pkg::BWidth-1:0]  b_coeff_1;
   logic [tpm_pkg::BWidth-1:0]  b_coeff_2;
   logic [tpm_pkg::BWidth-1:0]  b_coeff_3;

   modport source (
      output valid, a_coeff_0, a_coeff_1, a_coeff_2, a_coeff_3,
             b_coeff_0, b_coeff_1, b_coeff_2, b_coeff_3,
      input  ready
   );
   modport sink (
      input  valid, a_coeff_0, a_coeff_1, a_coeff_2, a_coeff_3,
             b_coeff_0, b_coeff_1, b_coeff_2, b_coeff_3,
      output ready
   );
endinterface

interface tpm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tpm_pkg::AWidth-1:0]  prod_coeff_0;
   logic [tpm_pkg::AWidth-1:0]  prod_coeff_1;
   logic [tpm_pkg::AWidth-1:0]  prod_coeff_2;
   logic [tpm_pkg::AWidth-1:0]  prod_coeff_3;

   modport source (
      output valid, prod_coeff_0, prod_coeff_1, prod_coeff_2, prod_coeff_3,
      input  ready
   );
   modport sink (
      input  valid, prod_coeff_0, prod_coeff_1, prod_coeff_2, prod_coeff_3,
      output ready
   );
endinterface

@@ sv/toom4_negacyclic_poly_mul_kernel_top.sv @@
// Channel   Dir  Beat contents
// req_chan  in   a_coeff_0..3 (24 bits), b_coeff_0..3 (8 bits)
// rsp_chan  out  prod_coeff_0..3 (24 bits), a*b mod (x^4 + 1) mod 2^24
//
// One beat is accepted per cycle unless a stall on rsp_chan backs up to the first stage.
// The pipeline has seven register stages: evaluation, the seven product lanes,
// three linear interpolation stages, the inverse multipliers and the output register.
// Reset is synchronous and empties the pipeline; no clearing pass is needed.
// A stall on rsp_chan holds only the stages that are full, so bubbles still fill behind it.

`include "assert_macros.svh"

module toom4_negacyclic_poly_mul_kernel_top (
   input  logic    clock,
   input  logic    reset,
   tpm_req_if.sink   req_chan,
   tpm_rsp_if.source rsp_chan
);

   localparam int N = tpm_pkg::NumStages;

   logic [N-1:0]          valid_ff;
   logic [N-1:0]          valid_in;
   logic [N-1:0]          adv;
   tpm_pkg::pipe_ctl_type ctl;
   tpm_pkg::a_poly_type   a_poly;
   tpm_pkg::b_poly_type   b_poly;
   tpm_pkg::x_vec_type    x_vec;
   tpm_pkg::y_vec_type    y_vec;
   tpm_pkg::w_vec_type    w_vec;
   tpm_pkg::prod_type     prod;

   always_comb begin
      adv[N-1] = !valid_ff[N-1] || rsp_chan.ready;
      for (int i = N - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? req_chan.valid : valid_ff[0];
      for (int i = 1; i < N; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load     = adv;
   assign req_chan.ready = adv[0];

   assign a_poly[0] = req_chan.a_coeff_0;
   assign a_poly[1] = req_chan.a_coeff_1;
   assign a_poly[2] = req_chan.a_coeff_2;
   assign a_poly[3] = req_chan.a_coeff_3;
   assign b_poly[0] = req_chan.b_coeff_0;
   assign b_poly[1] = req_chan.b_coeff_1;
   assign b_poly[2] = req_chan.b_coeff_2;
   assign b_poly[3] = req_chan.b_coeff_3;

   tpm_eval u_eval (
      .clock  (clock),
      .ctl    (ctl),
      .a_poly (a_poly),
      .b_poly (b_poly),
      .x_vec  (x_vec),
      .y_vec  (y_vec)
   );

   for (genvar p = 0; p < tpm_pkg::NumPoints; p++) begin : g_lane
      tpm_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .x     (x_vec[p]),
         .y     (y_vec[p]),
         .w     (w_vec[p])
      );
   end

   tpm_interp u_interp (
      .clock (clock),
      .ctl   (ctl),
      .w     (w_vec),
      .prod  (prod)
   );

   assign rsp_chan.valid        = valid_ff[N-1];
   assign rsp_chan.prod_coeff_0 = prod[0];
   assign rsp_chan.prod_coeff_1 = prod[1];
   assign rsp_chan.prod_coeff_2 = prod[2];
   assign rsp_chan.prod_coeff_3 = prod[3];

   `TPM_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (valid_ff == '0))
   `TPM_ASSERT(a_ready_when_drained, clock, reset, rsp_chan.ready |-> req_chan.ready)
   `TPM_ASSERT(a_accept_fills, clock, reset, (req_chan.valid && req_chan.ready) |=> valid_ff[0])
   `TPM_ASSERT(a_full_blocks, clock, reset, ((&valid_ff) && !rsp_chan.ready) |-> !req_chan.ready)

endmodule

@@ sv/tpm_eval.sv @@
module tpm_eval (
   input  logic                  clock,
   input  tpm_pkg::pipe_ctl_type ctl,
   input  tpm_pkg::a_poly_type   a_poly,
   input  tpm_pkg::b_poly_type   b_poly,
   output tpm_pkg::x_vec_type    x_vec,
   output tpm_pkg::y_vec_type    y_vec
);

   tpm_pkg::coeff_word_type a_word;
   tpm_pkg::coeff_word_type b_word;
   tpm_pkg::eval_type       ea;
   tpm_pkg::eval_type       eb;
   tpm_pkg::x_vec_type      x_in;
   tpm_pkg::y_vec_type      y_in;
   tpm_pkg::x_vec_type      x_ff;
   tpm_pkg::y_vec_type      y_ff;

   always_comb begin
      for (int i = 0; i < tpm_pkg::NumCoeffs; i++) begin
         a_word[i] = {8'd0, a_poly[i]};
         b_word[i] = {24'd0, b_poly[i]};
      end
      ea = tpm_pkg::evaluate(a_word);
      eb = tpm_pkg::evaluate(b_word);
      // Keep the low bits and let the top bit carry the sign of the full sum.
      for (int p = 0; p < tpm_pkg::NumPoints; p++) begin
         x_in[p] = {ea[p][31], ea[p][26:0]};
         y_in[p] = {eb[p][31], eb[p][11:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[tpm_pkg::StageEval]) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign x_vec = x_ff;
   assign y_vec = y_ff;

endmodule

@@ sv/tpm_lane.sv @@
module tpm_lane (
   input  logic                          clock,
   input  tpm_pkg::pipe_ctl_type         ctl,
   input  logic [tpm_pkg::XWidth-1:0]    x,
   input  logic [tpm_pkg::YWidth-1:0]    y,
   output logic [tpm_pkg::ModWidth-1:0]  w
);

   logic signed [tpm_pkg::XWidth-1:0]                 xs;
   logic signed [tpm_pkg::YWidth-1:0]                 ys;
   logic signed [tpm_pkg::XWidth+tpm_pkg::YWidth-1:0] prod;
   logic [tpm_pkg::ModWidth-1:0]                      w_in;
   logic [tpm_pkg::ModWidth-1:0]                      w_ff;

   assign xs   = $signed(x);
   assign ys   = $signed(y);
   assign prod = xs * ys;
   assign w_in = prod[tpm_pkg::ModWidth-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load[tpm_pkg::StageMul]) begin
         w_ff <= w_in;
      end
   end

   assign w = w_ff;

endmodule

@@ sv/tpm_interp.sv @@
module tpm_interp (
   input  logic                  clock,
   input  tpm_pkg::pipe_ctl_type ctl,
   input  tpm_pkg::w_vec_type    w,
   output tpm_pkg::prod_type     prod
);

   localparam int M = tpm_pkg::ModWidth;

   // First linear stage.
   logic [M-1:0] d32, r3a_in, r4a_in, r5a_in;
   logic [M-1:0] r3a_ff, r4a_ff, r5a_ff;
   logic [M-1:0] w0a_ff, w1a_ff, w2a_ff, w4a_ff, w6a_ff;

   // Second linear stage.
   logic [M-1:0] r2x, r1b_in, r2b_in;
   logic [M-1:0] r1b_ff, r2b_ff, r3b_ff, r4b_ff, r5b_ff, w0b_ff, w6b_ff;

   // Third linear stage, ending in the exact divisions by 8 and by 2.
   logic [M-1:0] r1c, d4, d5, d1;
   logic [M-1:0] r4p_in, r5p_in, r1p_in;
   logic [M-1:0] r4p_ff, r5p_ff, r1p_ff, r2c_ff, r3c_ff, w0c_ff, w6c_ff;

   // Multiplications by the odd inverses.
   logic [M-1:0] r4m_in, r1m_in, p15_in;
   logic [M-1:0] r4m_ff, r1m_ff, p15_ff, r2d_ff, r3d_ff, w0d_ff, w6d_ff;

   // Output stage.
   logic [M-1:0]                d15, r5f;
   logic [tpm_pkg::AWidth-1:0]  r2f, r1f;
   tpm_pkg::prod_type           prod_in;
   tpm_pkg::prod_type           prod_ff;

   always_comb begin
      d32    = w[3] - w[2];
      r3a_in = d32 >> 1;
      r4a_in = w[4] + w[5] - (w[0] << 1) - (w[6] << 7);
      r5a_in = w[5] - w[4];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[tpm_pkg::StageLinA]) begin
         r3a_ff <= r3a_in;
         r4a_ff <= r4a_in;
         r5a_ff <= r5a_in;
         w0a_ff <= w[0];
         w1a_ff <= w[1];
         w2a_ff <= w[2];
         w4a_ff <= w[4];
         w6a_ff <= w[6];
      end
   end

   always_comb begin
      r2x    = w2a_ff + r3a_ff;
      r1b_in = w1a_ff + w4a_ff - (r2x << 6) - r2x;
      r2b_in = r2x - w6a_ff - w0a_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[tpm_pkg::StageLinB]) begin
         r1b_ff <= r1b_in;
         r2b_ff <= r2b_in;
         r3b_ff <= r3a_ff;
         r4b_ff <= r4a_ff;
         r5b_ff <= r5a_ff;
         w0b_ff <= w0a_ff;
         w6b_ff <= w6a_ff;
      end
   end

   always_comb begin
      r1c    = r1b_ff + r2b_ff + (r2b_ff << 2) + (r2b_ff << 3) + (r2b_ff << 5);
      d4     = r4b_ff - (r2b_ff << 3);
      d5     = r5b_ff + r1c;
      d1     = r1c + (r3b_ff << 4);
      r4p_in = d4 >> 3;
      r5p_in = d5 >> 1;
      r1p_in = d1 >> 1;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[tpm_pkg::StageLinC]) begin
         r4p_ff <= r4p_in;
         r5p_ff <= r5p_in;
         r1p_ff <= r1p_in;
         r2c_ff <= r2b_ff;
         r3c_ff <= r3b_ff;
         w0c_ff <= w0b_ff;
         w6c_ff <= w6b_ff;
      end
   end

   always_comb begin
      r4m_in = r4p_ff * tpm_pkg::Inv3;
      r1m_in = r1p_ff * tpm_pkg::Inv9;
      p15_in = r5p_ff * tpm_pkg::Inv15;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[tpm_pkg::StageInv]) begin
         r4m_ff <= r4m_in;
         r1m_ff <= r1m_in;
         p15_ff <= p15_in;
         r2d_ff <= r2c_ff;
         r3d_ff <= r3c_ff;
         w0d_ff <= w0c_ff;
         w6d_ff <= w6c_ff;
      end
   end

   always_comb begin
      d15        = r1m_ff - p15_ff;
      r5f        = d15 >> 1;
      r2f        = r2d_ff[tpm_pkg::AWidth-1:0] - r4m_ff[tpm_pkg::AWidth-1:0];
      r1f        = r1m_ff[tpm_pkg::AWidth-1:0] - r5f[tpm_pkg::AWidth-1:0];
      prod_in[0] = w6d_ff[tpm_pkg::AWidth-1:0] - r2f;
      prod_in[1] = r5f[tpm_pkg::AWidth-1:0] - r1f;
      prod_in[2] = r4m_ff[tpm_pkg::AWidth-1:0] - w0d_ff[tpm_pkg::AWidth-1:0];
      prod_in[3] = tpm_pkg::AWidth'(0) - r3d_ff[tpm_pkg::AWidth-1:0]
                   - r1m_ff[tpm_pkg::AWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[tpm_pkg::StageOut]) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

@@ tb/toom4_negacyclic_poly_mul_kernel_top_tb.sv @@
module toom4_negacyclic_poly_mul_kernel_top_tb;

   localparam int ResetCycles = 7;
   localparam int PipeLatency = 7;
   localparam int CycleLimit  = 200000;

   localparam logic [31:0] Mask27       = 32'h7FFFFFF;
   localparam logic [31:0] RecipThree   = 32'hAAAAAAB;
   localparam logic [31:0] RecipNine    = 32'h8E38E39;
   localparam logic [31:0] RecipFifteen = 32'hEEEEEEF;

   typedef logic [31:0] u32_type;
   typedef u32_type [tpm_pkg::NumPoints-1:0] point_vals_type;

   logic clock = 1'b0;
   logic reset;

   tpm_req_if req_if ();
   tpm_rsp_if rsp_if ();

   toom4_negacyclic_poly_mul_kernel_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   tpm_pkg::prod_type expected_products[$];
   int       mismatch_count = 0;
   int       send_idle_pct  = 0;
   int       recv_stall_pct = 0;
   int       cycle_count    = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Values at inf, 2, 1, -1, 1/2 and -1/2 (both scaled by 8) and 0, mod 2^32.
   function automatic point_vals_type toom_points(input u32_type c0, input u32_type c1,
                                                  input u32_type c2, input u32_type c3);
      point_vals_type p;
      p[0] = c3;
      p[1] = c0 + (c1 << 1) + (c2 << 2) + (c3 << 3);
      p[2] = c0 + c1 + c2 + c3;
      p[3] = c0 - c1 + c2 - c3;
      p[4] = (c0 << 3) + (c1 << 2) + (c2 << 1) + c3;
      p[5] = (c0 << 3) - (c1 << 2) + (c2 << 1) - c3;
      p[6] = c0;
      return p;
   endfunction

   function automatic u32_type shift_signed28(input u32_type v, input int unsigned amount);
      u32_type fill;
      fill = (32'd0 - (u32_type'(v[27]) << (27 - amount))) & 32'hFFFFFFF;
      return (v >> amount) | fill;
   endfunction

   function automatic tpm_pkg::prod_type negacyclic_product(input tpm_pkg::a_poly_type a,
                                                            input tpm_pkg::b_poly_type b);
      point_vals_type    pa;
      point_vals_type    pb;
      point_vals_type    w;
      u32_type           x;
      u32_type           y;
      u32_type           t1;
      u32_type           t2;
      u32_type           t3;
      u32_type           t4;
      u32_type           t5;
      tpm_pkg::prod_type p;
      pa = toom_points(u32_type'(a[0]), u32_type'(a[1]), u32_type'(a[2]), u32_type'(a[3]));
      pb = toom_points(u32_type'(b[0]), u32_type'(b[1]), u32_type'(b[2]), u32_type'(b[3]));
      for (int i = 0; i < tpm_pkg::NumPoints; i++) begin
         x = (pa[i] & Mask27) | ((pa[i] >> 4) & 32'h8000000);
         y = (pb[i] & 32'hFFF) | ((pb[i] >> 19) & 32'h1000);
         x = x | (32'd0 - (x & 32'h8000000));
         y = y | (32'd0 - (y & 32'h1000));
         w[i] = (x * y) & Mask27;
      end
      t1 = (w[1] + w[4]) & Mask27;
      t5 = (w[5] - w[4]) & Mask27;
      t3 = shift_signed28((w[3] - w[2]) & Mask27, 1);
      t4 = (w[4] - w[0]) & Mask27;
      t4 = ((t4 << 1) + t5 - (w[6] << 7)) & Mask27;
      t2 = (w[2] + t3) & Mask27;
      t1 = (t1 - (t2 << 6) - t2) & Mask27;
      t2 = (t2 - w[6] - w[0]) & Mask27;
      t1 = (t1 + t2 + (t2 << 2) + (t2 << 3) + (t2 << 5)) & Mask27;
      t4 = (shift_signed28((t4 - (t2 << 3)) & Mask27, 3) * RecipThree) & Mask27;
      t5 = (t5 + t1) & Mask27;
      t1 = (shift_signed28((t1 + (t3 << 4)) & Mask27, 1) * RecipNine) & Mask27;
      t2 = (t2 - t4) & Mask27;
      t3 = (32'd0 - t3 - t1) & Mask27;
      t5 = shift_signed28((t1 - ((shift_signed28(t5, 1) * RecipFifteen) & Mask27))
                          & Mask27, 1);
      t1 = t1 - t5;
      p[0] = tpm_pkg::AWidth'(w[6] - t2);
      p[1] = tpm_pkg::AWidth'(t5 - t1);
      p[2] = tpm_pkg::AWidth'(t4 - w[0]);
      p[3] = tpm_pkg::AWidth'(t3);
      return p;
   endfunction

   function automatic u32_type random_coeff(input int bits);
      u32_type field_mask;
      u32_type v;
      field_mask = (32'd1 << bits) - 32'd1;
      case ($urandom_range(7))
         0: v = 32'd0;
         1: v = field_mask;
         2: v = $urandom_range(15);
         3: v = field_mask - $urandom_range(15);
         default: v = $urandom();
      endcase
      return v & field_mask;
   endfunction

   task automatic drive_payload(input tpm_pkg::a_poly_type a, input tpm_pkg::b_poly_type b);
      req_if.a_coeff_0 <= a[0];
      req_if.a_coeff_1 <= a[1];
      req_if.a_coeff_2 <= a[2];
      req_if.a_coeff_3 <= a[3];
      req_if.b_coeff_0 <= b[0];
      req_if.b_coeff_1 <= b[1];
      req_if.b_coeff_2 <= b[2];
      req_if.b_coeff_3 <= b[3];
   endtask

   // Called just after a falling edge; returns just after the falling edge that follows acceptance.
   task automatic send_product_request(input tpm_pkg::a_poly_type a,
                                       input tpm_pkg::b_poly_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         drive_payload(tpm_pkg::a_poly_type'({$urandom(), $urandom(), $urandom()}),
                       tpm_pkg::b_poly_type'($urandom()));
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      drive_payload(a, b);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_products.push_back(negacyclic_product(a, b));
      @(negedge clock);
   endtask

   task automatic send_coeffs(input logic [tpm_pkg::AWidth-1:0] a0,
                              input logic [tpm_pkg::AWidth-1:0] a1,
                              input logic [tpm_pkg::AWidth-1:0] a2,
                              input logic [tpm_pkg::AWidth-1:0] a3,
                              input logic [tpm_pkg::BWidth-1:0] b0,
                              input logic [tpm_pkg::BWidth-1:0] b1,
                              input logic [tpm_pkg::BWidth-1:0] b2,
                              input logic [tpm_pkg::BWidth-1:0] b3);
      send_product_request({a3, a2, a1, a0}, {b3, b2, b1, b0});
   endtask

   task automatic send_random_products(input int count);
      tpm_pkg::a_poly_type a;
      tpm_pkg::b_poly_type b;
      repeat (count) begin
         for (int k = 0; k < tpm_pkg::NumCoeffs; k++) begin
            a[k] = tpm_pkg::AWidth'(random_coeff(tpm_pkg::AWidth));
            b[k] = tpm_pkg::BWidth'(random_coeff(tpm_pkg::BWidth));
         end
         send_product_request(a, b);
      end
   endtask

   task automatic wait_for_products();
      req_if.valid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed_corners();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_coeffs(24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_coeffs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_coeffs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  8'h00, 8'h00, 8'h00, 8'h00);
      send_coeffs(24'h0, 24'h0, 24'h0, 24'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_coeffs(24'h1, 24'h0, 24'h0, 24'h0, 8'h01, 8'h00, 8'h00, 8'h00);
      // The x^3 by x^3 term wraps around to minus x^2.
      send_coeffs(24'h0, 24'h0, 24'h0, 24'h1, 8'h00, 8'h00, 8'h00, 8'h01);
      send_coeffs(24'hFFFFFF, 24'h0, 24'h0, 24'h0, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_coeffs(24'h0, 24'h0, 24'h0, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_coeffs(24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'h0, 8'hFF, 8'h00, 8'hFF, 8'h00);
      send_coeffs(24'h0, 24'hFFFFFF, 24'h0, 24'hFFFFFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
      send_coeffs(24'h123456, 24'hABCDEF, 24'h0F1E2D, 24'hFEDCBA,
                  8'h01, 8'h00, 8'h00, 8'h00);
      send_coeffs(24'h800000, 24'h800000, 24'h800000, 24'h800000,
                  8'h80, 8'h80, 8'h80, 8'h80);
      send_coeffs(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                  8'h7F, 8'h7F, 8'h7F, 8'h7F);
      send_coeffs(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                  8'hAA, 8'h55, 8'hAA, 8'h55);
      send_coeffs(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                  8'h55, 8'hAA, 8'h55, 8'hAA);
      send_coeffs(24'h1, 24'h1, 24'h1, 24'h1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_coeffs(24'hFFFFFF, 24'hFFFFFE, 24'h000001, 24'h7FFFFF,
                  8'h00, 8'h01, 8'h00, 8'h00);
      send_coeffs(24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'hFFFFFF,
                  8'hFF, 8'hFE, 8'h01, 8'h80);
      wait_for_products();
   endtask

   task automatic test_back_to_back();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random_products(130);
      wait_for_products();
   endtask

   task automatic test_sender_gaps();
      send_idle_pct  = 87;
      recv_stall_pct = 0;
      send_random_products(60);
      // The sender holds off here until the pipeline has drained completely.
      wait_for_products();
      send_random_products(60);
      wait_for_products();
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct  = 0;
      recv_stall_pct = 87;
      send_random_products(130);
      wait_for_products();
   endtask

   task automatic test_mixed_idling();
      send_idle_pct  = 18;
      recv_stall_pct = 18;
      send_random_products(130);
      wait_for_products();
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic check_coeff(input string field, input logic [tpm_pkg::AWidth-1:0] want,
                              input logic [tpm_pkg::AWidth-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      tpm_pkg::prod_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_products.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_products.pop_front();
            check_coeff("prod_coeff_0", want[0], rsp_if.prod_coeff_0);
            check_coeff("prod_coeff_1", want[1], rsp_if.prod_coeff_1);
            check_coeff("prod_coeff_2", want[2], rsp_if.prod_coeff_2);
            check_coeff("prod_coeff_3", want[3], rsp_if.prod_coeff_3);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      rsp_if.ready = 1'b0;
      drive_payload('0, '0);
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_back_to_back();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      repeat (PipeLatency + 3) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
